// ===== sv/adc_two_point_calibration_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the two-point calibration core
// Shared helpers that keep the concurrent checks short and uniform.
// ----------------------------------------------------------------------------
`ifndef ADC_TWO_POINT_CALIBRATION_CORE_ASSERT_SVH
`define ADC_TWO_POINT_CALIBRATION_CORE_ASSERT_SVH

// The condition must hold in the same cycle as the trigger.
`define TPC_ASSERT_SAME(label, clk, rst_n, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error(msg);

// The condition must hold in the cycle after the trigger.
`define TPC_ASSERT_NEXT(label, clk, rst_n, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

// ===== sv/adc_tpc_pkg.sv =====
// ----------------------------------------------------------------------------
// adc_tpc_pkg
// Widths, reset values, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package adc_tpc_pkg;

    localparam int SAMPLE_W   = 12;
    localparam int MODE_W     = 2;
    localparam int CORR_W     = 16;
    localparam int GAIN_W     = 25;
    localparam int OFFSET_W   = 16;
    localparam int SLOT_W     = 3;
    localparam int ROUND_W    = 8;
    localparam int RSUM_W     = 16;
    localparam int TOTAL_W    = 20;
    localparam int PAIR_W     = SAMPLE_W + 1;
    localparam int RSUM_SHIFT = 3;
    localparam int Q_FRAC     = 12;
    localparam int MEAS_SHIFT = 13;
    localparam int CFG_ADDR_W = 2;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 64;
    localparam int OUT_PAD_W  = OUT_DATA_W - (CORR_W + 3 + GAIN_W + OFFSET_W);

    localparam int ROUNDS_LOG2_DEFAULT     = 5;
    localparam int SLOTS_PER_ROUND_DEFAULT = 8;

    localparam logic [SAMPLE_W-1:0] IDEAL_LOW_RESET  = 12'd1365;
    localparam logic [SAMPLE_W-1:0] IDEAL_HIGH_RESET = 12'd3413;
    localparam logic [GAIN_W-1:0]   GAIN_RESET       = 25'd4096;
    localparam logic [CORR_W-1:0]   CORR_MAX         = 16'hFFFF;

    typedef enum logic [MODE_W-1:0] {
        MODE_REF     = 2'd0,
        MODE_MEAS    = 2'd1,
        MODE_RESTART = 2'd2
    } mode_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_IDEAL_LOW  = 2'd0,
        CFG_IDEAL_HIGH = 2'd1
    } cfg_index_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_CORRECT,
        S_CAL_CHECK,
        S_DIV_RUN,
        S_OFFSET_MUL,
        S_OFFSET_SET,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic capture;
        logic accumulate;
        logic mul_meas;
        logic correct;
        logic clear_acc;
        logic set_error;
        logic div_start;
        logic mul_offset;
        logic commit_cal;
        logic emit;
    } dp_cmd_t;

    typedef struct packed {
        mode_t mode;
        logic  cal_end;
        logic  div_zero;
        logic  div_done;
        logic  out_free;
    } dp_status_t;

endpackage

// ===== sv/adc_tpc_div.sv =====
// ----------------------------------------------------------------------------
// adc_tpc_div
// Signed restoring divider, one quotient bit per cycle, truncating toward zero.
// ----------------------------------------------------------------------------
module adc_tpc_div
    import adc_tpc_pkg::*;
#(
    parameter int DEN_W = 15
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic signed [GAIN_W-1:0] num,
    input  logic signed [DEN_W:0]    den,
    output logic                     done,
    output logic signed [GAIN_W-1:0] quotient
);

    localparam int NUM_MAG_W = GAIN_W - 1;
    localparam int CNT_W     = $clog2(NUM_MAG_W + 1);

    logic                     busy_reg, busy_next;
    logic                     fin_reg, fin_next;
    logic                     done_reg;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic [NUM_MAG_W-1:0]     work_reg;
    logic [DEN_W-1:0]         rem_reg;
    logic [DEN_W-1:0]         den_reg;
    logic                     neg_reg;
    logic signed [GAIN_W-1:0] quo_reg;

    logic signed [GAIN_W-1:0] num_abs;
    logic signed [DEN_W:0]    den_abs;
    logic [DEN_W:0]           trial;
    logic [DEN_W:0]           trial_diff;
    logic                     fits;
    logic signed [GAIN_W-1:0] mag_signed;

    assign num_abs    = num[GAIN_W-1] ? -num : num;
    assign den_abs    = den[DEN_W] ? -den : den;
    // The remainder stays below the divisor, so it always fits DEN_W bits.
    assign trial      = {rem_reg, work_reg[NUM_MAG_W-1]};
    assign trial_diff = trial - {1'b0, den_reg};
    assign fits       = trial >= {1'b0, den_reg};
    assign mag_signed = $signed({1'b0, work_reg});

    always_comb
    begin
        busy_next = busy_reg;
        fin_next  = 1'b0;
        cnt_next  = cnt_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(NUM_MAG_W);
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                fin_next  = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            fin_reg  <= fin_next;
            done_reg <= fin_reg;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            work_reg <= num_abs[NUM_MAG_W-1:0];
            den_reg  <= den_abs[DEN_W-1:0];
            rem_reg  <= '0;
            neg_reg  <= num[GAIN_W-1] ^ den[DEN_W];
        end
        else if (busy_reg)
        begin
            work_reg <= {work_reg[NUM_MAG_W-2:0], fits};
            rem_reg  <= fits ? trial_diff[DEN_W-1:0] : trial[DEN_W-1:0];
        end
        if (fin_reg)
        begin
            quo_reg <= neg_reg ? -mag_signed : mag_signed;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== sv/adc_tpc_datapath.sv =====
// ----------------------------------------------------------------------------
// adc_tpc_datapath
// Reference accumulation, gain/offset registers, shared multiplier,
// correction and clamping, calibration arithmetic and the result register.
// ----------------------------------------------------------------------------
`include "adc_two_point_calibration_core_assert.svh"

module adc_tpc_datapath
    import adc_tpc_pkg::*;
#(
    parameter int ROUNDS_LOG2     = ROUNDS_LOG2_DEFAULT,
    parameter int SLOTS_PER_ROUND = SLOTS_PER_ROUND_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [SAMPLE_W-1:0]   cfg_wdata,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic [MODE_W-1:0]     s_tuser,
    input  dp_cmd_t               cmd,
    output dp_status_t            status,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata
);

    localparam int AVG_W   = TOTAL_W - ROUNDS_LOG2;
    localparam int MUL_A_W = (AVG_W > PAIR_W) ? AVG_W : PAIR_W;
    localparam int PROD_W  = MUL_A_W + 1 + GAIN_W;
    localparam int V_W     = PROD_W - MEAS_SHIFT + 1;
    localparam logic [SLOT_W-1:0]  SLOT_LAST  = SLOT_W'(SLOTS_PER_ROUND - 1);
    localparam logic [ROUND_W-1:0] ROUND_LAST = ROUND_W'((1 << ROUNDS_LOG2) - 1);
    localparam logic [PROD_W-1:0]  ROUND_HALF = PROD_W'(1) << (Q_FRAC - 1);

    // Configuration
    logic [SAMPLE_W-1:0] ideal_low_reg, ideal_high_reg;

    // Captured item
    mode_t               mode_reg;
    logic [SAMPLE_W-1:0] first_reg, second_reg;

    // Accumulation state
    logic [SLOT_W-1:0]  slot_reg, slot_next;
    logic [ROUND_W-1:0] round_reg, round_next;
    logic [RSUM_W-1:0]  rhigh_reg, rhigh_next;
    logic [RSUM_W-1:0]  rlow_reg, rlow_next;
    logic [TOTAL_W-1:0] thigh_reg, thigh_next;
    logic [TOTAL_W-1:0] tlow_reg, tlow_next;

    // Calibration results
    logic signed [GAIN_W-1:0]   gain_reg, gain_next;
    logic signed [OFFSET_W-1:0] offset_reg, offset_next;
    logic                       done_reg, done_next;
    logic                       error_reg, error_next;

    // Arithmetic
    logic signed [PROD_W-1:0] prod_reg;
    logic [CORR_W-1:0]        corr_reg;
    logic                     sat_reg;

    // Result register
    logic                  out_valid_reg, out_valid_next;
    logic [OUT_DATA_W-1:0] out_data_reg;

    logic [SAMPLE_W-1:0]      add_high, add_low;
    logic [RSUM_W-1:0]        rh_sum, rl_sum;
    logic                     last_slot, last_round;
    logic [AVG_W-1:0]         avg_high, avg_low;
    logic signed [AVG_W:0]    div_den;
    logic signed [PAIR_W-1:0] ideal_diff;
    logic signed [GAIN_W-1:0] div_num;
    logic                     div_done;
    logic signed [GAIN_W-1:0] quotient;
    logic [PAIR_W-1:0]        pair_sum;
    logic [MUL_A_W-1:0]       mul_a;
    logic signed [GAIN_W-1:0] mul_b;
    logic signed [PROD_W-1:0] mul_p;
    logic signed [V_W-1:0]    corr_sum;
    logic [CORR_W-1:0]        corr_val;
    logic                     sat_val;
    logic [PROD_W-1:0]        off_round;
    logic [OFFSET_W-1:0]      off_new;
    logic [CORR_W-1:0]        res_value;
    logic                     res_sat;
    logic                     out_free;

    // Even slots carry the high reference on the first converter.
    assign add_high   = slot_reg[0] ? second_reg : first_reg;
    assign add_low    = slot_reg[0] ? first_reg : second_reg;
    assign rh_sum     = rhigh_reg + RSUM_W'(add_high);
    assign rl_sum     = rlow_reg + RSUM_W'(add_low);
    assign last_slot  = slot_reg >= SLOT_LAST;
    assign last_round = round_reg >= ROUND_LAST;

    assign avg_high   = thigh_reg[TOTAL_W-1:ROUNDS_LOG2];
    assign avg_low    = tlow_reg[TOTAL_W-1:ROUNDS_LOG2];
    assign div_den    = $signed({1'b0, avg_high}) - $signed({1'b0, avg_low});
    assign ideal_diff = $signed({1'b0, ideal_high_reg}) - $signed({1'b0, ideal_low_reg});
    assign div_num    = {ideal_diff, {Q_FRAC{1'b0}}};

    adc_tpc_div #(
        .DEN_W (AVG_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .num      (div_num),
        .den      (div_den),
        .done     (div_done),
        .quotient (quotient)
    );

    // One multiplier serves both the measurement and the offset derivation.
    assign pair_sum = {1'b0, first_reg} + {1'b0, second_reg};
    assign mul_a    = cmd.mul_offset ? MUL_A_W'(avg_low) : MUL_A_W'(pair_sum);
    assign mul_b    = cmd.mul_offset ? quotient : gain_reg;
    assign mul_p    = $signed({1'b0, mul_a}) * mul_b;

    // The part-select of the product is the floor of the shift.
    assign corr_sum = V_W'($signed(prod_reg[PROD_W-1:MEAS_SHIFT])) + V_W'(offset_reg);

    always_comb
    begin
        if (corr_sum[V_W-1])
        begin
            corr_val = '0;
            sat_val  = 1'b0;
        end
        else if (|corr_sum[V_W-2:CORR_W])
        begin
            corr_val = CORR_MAX;
            sat_val  = 1'b1;
        end
        else
        begin
            corr_val = corr_sum[CORR_W-1:0];
            sat_val  = 1'b0;
        end
    end

    // Only bits 27:12 of the rounded product (its low 16 integer bits) reach the offset.
    assign off_round = prod_reg + ROUND_HALF;
    assign off_new   = OFFSET_W'(ideal_low_reg) - off_round[Q_FRAC+OFFSET_W-1:Q_FRAC];

    always_comb
    begin
        slot_next  = slot_reg;
        round_next = round_reg;
        rhigh_next = rhigh_reg;
        rlow_next  = rlow_reg;
        thigh_next = thigh_reg;
        tlow_next  = tlow_reg;
        if (cmd.clear_acc)
        begin
            slot_next  = '0;
            round_next = '0;
            rhigh_next = '0;
            rlow_next  = '0;
            thigh_next = '0;
            tlow_next  = '0;
        end
        else if (cmd.accumulate)
        begin
            if (last_slot)
            begin
                slot_next  = '0;
                rhigh_next = '0;
                rlow_next  = '0;
                thigh_next = thigh_reg + TOTAL_W'(rh_sum >> RSUM_SHIFT);
                tlow_next  = tlow_reg + TOTAL_W'(rl_sum >> RSUM_SHIFT);
                // On the last round the counters are cleared after calibration.
                if (!last_round)
                begin
                    round_next = round_reg + 1'b1;
                end
            end
            else
            begin
                slot_next  = slot_reg + 1'b1;
                rhigh_next = rh_sum;
                rlow_next  = rl_sum;
            end
        end
    end

    always_comb
    begin
        gain_next   = gain_reg;
        offset_next = offset_reg;
        done_next   = done_reg;
        error_next  = error_reg;
        if (cmd.commit_cal)
        begin
            gain_next   = quotient;
            offset_next = $signed(off_new);
            done_next   = 1'b1;
            error_next  = 1'b0;
        end
        else if (cmd.set_error)
        begin
            error_next = 1'b1;
        end
    end

    assign out_free       = !out_valid_reg || m_tready;
    assign out_valid_next = cmd.emit ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);
    assign res_value      = (mode_reg == MODE_MEAS) ? corr_reg : '0;
    assign res_sat        = (mode_reg == MODE_MEAS) ? sat_reg : 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ideal_low_reg  <= IDEAL_LOW_RESET;
            ideal_high_reg <= IDEAL_HIGH_RESET;
            mode_reg       <= MODE_REF;
            slot_reg       <= '0;
            round_reg      <= '0;
            rhigh_reg      <= '0;
            rlow_reg       <= '0;
            thigh_reg      <= '0;
            tlow_reg       <= '0;
            gain_reg       <= $signed(GAIN_RESET);
            offset_reg     <= '0;
            done_reg       <= 1'b0;
            error_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index_t'(cfg_addr))
                    CFG_IDEAL_LOW:  ideal_low_reg  <= cfg_wdata;
                    CFG_IDEAL_HIGH: ideal_high_reg <= cfg_wdata;
                    default:        ;
                endcase
            end
            if (cmd.capture)
            begin
                mode_reg <= mode_t'(s_tuser);
            end
            slot_reg      <= slot_next;
            round_reg     <= round_next;
            rhigh_reg     <= rhigh_next;
            rlow_reg      <= rlow_next;
            thigh_reg     <= thigh_next;
            tlow_reg      <= tlow_next;
            gain_reg      <= gain_next;
            offset_reg    <= offset_next;
            done_reg      <= done_next;
            error_reg     <= error_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            first_reg  <= s_tdata[SAMPLE_W-1:0];
            second_reg <= s_tdata[2*SAMPLE_W-1:SAMPLE_W];
        end
        if (cmd.mul_meas || cmd.mul_offset)
        begin
            prod_reg <= mul_p;
        end
        if (cmd.correct)
        begin
            corr_reg <= corr_val;
            sat_reg  <= sat_val;
        end
        if (cmd.emit)
        begin
            out_data_reg <= {{OUT_PAD_W{1'b0}}, offset_reg, gain_reg, error_reg, done_reg,
                             res_sat, res_value};
        end
    end

    assign status.mode     = mode_reg;
    assign status.cal_end  = last_slot && last_round;
    assign status.div_zero = (avg_high == avg_low);
    assign status.div_done = div_done;
    assign status.out_free = out_free;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    `TPC_ASSERT_SAME(a_emit_slot_free, clk, rst_n, cmd.emit, out_free, "result loaded over a pending one")
    `TPC_ASSERT_SAME(a_div_nonzero, clk, rst_n, cmd.div_start, avg_high != avg_low, "division started with zero divisor")
    `TPC_ASSERT_NEXT(a_commit_flags, clk, rst_n, cmd.commit_cal, done_reg && !error_reg, "calibration commit left wrong flags")
    `TPC_ASSERT_NEXT(a_clear_counters, clk, rst_n, cmd.clear_acc, slot_reg == '0 && round_reg == '0 && thigh_reg == '0, "accumulation not cleared")

endmodule

// ===== sv/adc_tpc_ctrl.sv =====
// ----------------------------------------------------------------------------
// adc_tpc_ctrl
// Sequencer that walks one item through update, multiply, divide and result.
// ----------------------------------------------------------------------------
module adc_tpc_ctrl
    import adc_tpc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                case (status.mode)
                    MODE_REF:  state_next = status.cal_end ? S_CAL_CHECK : S_EMIT;
                    MODE_MEAS: state_next = S_CORRECT;
                    default:   state_next = S_EMIT;
                endcase
            end
            S_CORRECT:    state_next = S_EMIT;
            S_CAL_CHECK:  state_next = status.div_zero ? S_EMIT : S_DIV_RUN;
            S_DIV_RUN:
            begin
                if (status.div_done)
                begin
                    state_next = S_OFFSET_MUL;
                end
            end
            S_OFFSET_MUL: state_next = S_OFFSET_SET;
            S_OFFSET_SET: state_next = S_EMIT;
            S_EMIT:
            begin
                if (status.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:      state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
            end
            S_EXEC:
            begin
                case (status.mode)
                    MODE_REF:     cmd.accumulate = 1'b1;
                    MODE_MEAS:    cmd.mul_meas   = 1'b1;
                    MODE_RESTART: cmd.clear_acc  = 1'b1;
                    default:      ;
                endcase
            end
            S_CORRECT:    cmd.correct = 1'b1;
            S_CAL_CHECK:
            begin
                // Equal averages keep gain and offset but still restart.
                if (status.div_zero)
                begin
                    cmd.set_error = 1'b1;
                    cmd.clear_acc = 1'b1;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                end
            end
            S_DIV_RUN:    ;
            S_OFFSET_MUL: cmd.mul_offset = 1'b1;
            S_OFFSET_SET:
            begin
                cmd.commit_cal = 1'b1;
                cmd.clear_acc  = 1'b1;
            end
            S_EMIT:       cmd.emit = status.out_free;
            default:      ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== sv/adc_two_point_calibration_core.sv =====
// ----------------------------------------------------------------------------
// adc_two_point_calibration_core
// Two-point gain/offset calibration and correction for a dual 12-bit ADC.
// Each transaction on the input stream yields exactly one transaction on the
// output stream, in order. Reference and restart items pass through the
// idle, execute and emit states, and measurement items add a correct state
// for shift, offset and clamp after the shared 16x25 multiplier. The
// reference item that closes a calibration also passes the check state, the
// restoring divider that produces one quotient bit per cycle over 24 bits,
// and the offset multiply. A new transaction is accepted once the previous
// one has been placed in the output register, which holds it while the sink
// stalls. Configuration writes must be issued while the block is idle.
// ----------------------------------------------------------------------------
module adc_two_point_calibration_core
    import adc_tpc_pkg::*;
#(
    parameter int ROUNDS_LOG2     = ROUNDS_LOG2_DEFAULT,
    parameter int SLOTS_PER_ROUND = SLOTS_PER_ROUND_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [SAMPLE_W-1:0]   cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // [11:0] first_sample, [23:12] second_sample
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // [1:0] mode
    input  logic [MODE_W-1:0]     s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [15:0] corrected_value, [16] value_saturated, [17] calibration_done,
    // [18] calibration_error, [43:19] gain_now, [59:44] offset_now, [63:60] zero
    output logic [OUT_DATA_W-1:0] m_tdata
);

    dp_cmd_t    cmd;
    dp_status_t status;

    adc_tpc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    adc_tpc_datapath #(
        .ROUNDS_LOG2     (ROUNDS_LOG2),
        .SLOTS_PER_ROUND (SLOTS_PER_ROUND)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd       (cmd),
        .status    (status),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for adc_two_point_calibration_core
// Streams reference, measurement, restart and unused-mode words into the
// core and checks every result word against a cycle-free model of the
// calibration and correction arithmetic. The run covers a complete
// calibration with reversed ideal codes and reversed reference levels, whose
// large gain saturates high sums and clamps low ones, and a calibration with
// equal averages that must raise the error flag. Both stream sides idle at
// random.
// ----------------------------------------------------------------------------
module testbench;
    import adc_tpc_pkg::*;

    localparam int IDLE_PCT   = 26;
    localparam int SAMPLE_MAX = (1 << SAMPLE_W) - 1;
    localparam int CAL_REFS   = SLOTS_PER_ROUND_DEFAULT << ROUNDS_LOG2_DEFAULT;
    localparam logic [MODE_W-1:0]     MODE_UNUSED = 2'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_SPARE   = 2'd3;

    typedef struct {
        logic [MODE_W-1:0]   mode;
        logic [SAMPLE_W-1:0] first_code;
        logic [SAMPLE_W-1:0] second_code;
    } conversion_t;

    // Members run from the top of the output word down to bit 0.
    typedef struct packed {
        logic [OUT_PAD_W-1:0] pad;
        logic [OFFSET_W-1:0]  offset;
        logic [GAIN_W-1:0]    gain;
        logic                 err;
        logic                 done;
        logic                 sat;
        logic [CORR_W-1:0]    value;
    } reading_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = CFG_IDEAL_LOW;
    logic [SAMPLE_W-1:0]   cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;
    logic [MODE_W-1:0]     s_tuser   = MODE_REF;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;

    conversion_t conversion_queue[$];
    reading_t    expected_readings[$];
    logic        in_fire = 1'b0;
    logic        steady  = 1'b0;
    int          mismatches      = 0;
    int          readings_checked = 0;
    int          mode_count[4]   = '{default: 0};
    int          cal_closed      = 0;
    int          cal_failed      = 0;
    int          saturated_count = 0;
    int          clamped_count   = 0;

    // Model state of the core.
    logic [SAMPLE_W-1:0]        ideal_low_code  = IDEAL_LOW_RESET;
    logic [SAMPLE_W-1:0]        ideal_high_code = IDEAL_HIGH_RESET;
    int unsigned                slot_cnt  = 0;
    int unsigned                round_cnt = 0;
    logic [RSUM_W-1:0]          round_hi  = '0;
    logic [RSUM_W-1:0]          round_lo  = '0;
    logic [TOTAL_W-1:0]         total_hi  = '0;
    logic [TOTAL_W-1:0]         total_lo  = '0;
    logic signed [GAIN_W-1:0]   gain_q12  = GAIN_RESET;
    logic signed [OFFSET_W-1:0] offset_code = '0;
    logic                       cal_done  = 1'b0;
    logic                       cal_err   = 1'b0;

    adc_two_point_calibration_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #5 clk = ~clk;

    function automatic void restart_accumulation();
        slot_cnt  = 0;
        round_cnt = 0;
        round_hi  = '0;
        round_lo  = '0;
        total_hi  = '0;
        total_lo  = '0;
    endfunction

    function automatic void derive_gain_offset();
        int     avg_h;
        int     avg_l;
        int     divisor;
        int     numer;
        int     g;
        longint scaled;
        longint diff;
        avg_h   = int'(total_hi >> ROUNDS_LOG2_DEFAULT);
        avg_l   = int'(total_lo >> ROUNDS_LOG2_DEFAULT);
        divisor = avg_h - avg_l;
        if (divisor == 0)
        begin
            cal_err = 1'b1;
            cal_failed++;
        end
        else
        begin
            numer  = (int'(ideal_high_code) - int'(ideal_low_code)) * (1 << Q_FRAC);
            g      = numer / divisor;
            // Arithmetic shift of a signed value rounds toward minus infinity.
            scaled = (longint'(avg_l) * longint'(g) + (1 << (Q_FRAC - 1))) >>> Q_FRAC;
            diff   = longint'(ideal_low_code) - scaled;
            gain_q12    = g[GAIN_W-1:0];
            offset_code = diff[OFFSET_W-1:0];
            cal_done = 1'b1;
            cal_err  = 1'b0;
            cal_closed++;
        end
        restart_accumulation();
    endfunction

    function automatic void steer_reference(input logic [SAMPLE_W-1:0] a,
                                            input logic [SAMPLE_W-1:0] b);
        if (slot_cnt % 2 == 0)
        begin
            round_hi = round_hi + a;
            round_lo = round_lo + b;
        end
        else
        begin
            round_hi = round_hi + b;
            round_lo = round_lo + a;
        end
        if (slot_cnt >= SLOTS_PER_ROUND_DEFAULT - 1)
        begin
            slot_cnt = 0;
            total_hi = total_hi + (round_hi >> RSUM_SHIFT);
            total_lo = total_lo + (round_lo >> RSUM_SHIFT);
            round_hi = '0;
            round_lo = '0;
            if (round_cnt >= (1 << ROUNDS_LOG2_DEFAULT) - 1)
                derive_gain_offset();
            else
                round_cnt = (round_cnt + 1) % 256;
        end
        else
            slot_cnt++;
    endfunction

    function automatic reading_t apply_conversion(input logic [MODE_W-1:0]   mode,
                                                  input logic [SAMPLE_W-1:0] a,
                                                  input logic [SAMPLE_W-1:0] b);
        reading_t r;
        longint   v;
        r = '0;
        mode_count[mode]++;
        case (mode)
            MODE_REF:
                steer_reference(a, b);
            MODE_MEAS:
            begin
                v = ((longint'(a) + longint'(b)) * longint'(gain_q12)) >>> MEAS_SHIFT;
                v = v + longint'(offset_code);
                if (v < 0)
                    clamped_count++;
                else if (v > longint'(CORR_MAX))
                begin
                    r.value = CORR_MAX;
                    r.sat   = 1'b1;
                    saturated_count++;
                end
                else
                    r.value = v[CORR_W-1:0];
            end
            MODE_RESTART:
                restart_accumulation();
            default:
                ;
        endcase
        r.done   = cal_done;
        r.err    = cal_err;
        r.gain   = gain_q12;
        r.offset = offset_code;
        return r;
    endfunction

    task automatic flag_mismatch(input string what, input longint got, input longint want);
        mismatches++;
        $display("[%0t] %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    task automatic check_reading(input reading_t got);
        reading_t want;
        if (expected_readings.size() == 0)
        begin
            flag_mismatch("result with no conversion pending", got.value, 0);
            return;
        end
        want = expected_readings.pop_front();
        readings_checked++;
        if (got.value !== want.value)
            flag_mismatch("corrected_value", got.value, want.value);
        if (got.sat !== want.sat)
            flag_mismatch("value_saturated", got.sat, want.sat);
        if (got.done !== want.done)
            flag_mismatch("calibration_done", got.done, want.done);
        if (got.err !== want.err)
            flag_mismatch("calibration_error", got.err, want.err);
        if (got.gain !== want.gain)
            flag_mismatch("gain_now", $signed(got.gain), $signed(want.gain));
        if (got.offset !== want.offset)
            flag_mismatch("offset_now", $signed(got.offset), $signed(want.offset));
        if (got.pad !== want.pad)
            flag_mismatch("padding bits", got.pad, want.pad);
    endtask

    // Results are checked before the input side so that a transaction leaving and
    // one entering at the same edge keep their order in the queue.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            check_reading(m_tdata);
        if (rst_n && cfg_we)
        begin
            case (cfg_addr)
                CFG_IDEAL_LOW:  ideal_low_code  = cfg_wdata;
                CFG_IDEAL_HIGH: ideal_high_code = cfg_wdata;
                default:        ;
            endcase
        end
        in_fire = rst_n && s_tvalid && s_tready;
        if (in_fire)
            expected_readings.push_back(apply_conversion(s_tuser,
                s_tdata[SAMPLE_W-1:0], s_tdata[2*SAMPLE_W-1:SAMPLE_W]));
    end

    always @(negedge clk)
    begin
        conversion_t next_conv;
        if (!rst_n)
            s_tvalid <= 1'b0;
        else if (!s_tvalid || in_fire)
        begin
            if (conversion_queue.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT))
            begin
                next_conv = conversion_queue.pop_front();
                s_tvalid  <= 1'b1;
                s_tuser   <= next_conv.mode;
                s_tdata   <= {next_conv.second_code, next_conv.first_code};
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    always @(negedge clk)
        m_tready <= steady || ($urandom_range(99) >= IDLE_PCT);

    task automatic queue_conversion(input logic [MODE_W-1:0]   mode,
                                    input logic [SAMPLE_W-1:0] a,
                                    input logic [SAMPLE_W-1:0] b);
        conversion_t c;
        c.mode        = mode;
        c.first_code  = a;
        c.second_code = b;
        conversion_queue.push_back(c);
    endtask

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(7))
            0:       return '0;
            1:       return SAMPLE_MAX;
            default: return SAMPLE_W'($urandom_range(SAMPLE_MAX));
        endcase
    endfunction

    function automatic logic [SAMPLE_W-1:0] near_level(input int level, input int spread);
        int v;
        v = level + int'($urandom_range(2 * spread)) - spread;
        if (v < 0)
            v = 0;
        else if (v > SAMPLE_MAX)
            v = SAMPLE_MAX;
        return v[SAMPLE_W-1:0];
    endfunction

    task automatic wait_all_results();
        while (conversion_queue.size() != 0 || s_tvalid || expected_readings.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_ideal(input logic [CFG_ADDR_W-1:0] idx,
                               input logic [SAMPLE_W-1:0]   val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic queue_measurements(input int n);
        for (int k = 0; k < n; k++)
            queue_conversion(MODE_MEAS, pick_sample(), pick_sample());
    endtask

    task automatic queue_noise(input int n);
        for (int k = 0; k < n; k++)
            queue_conversion(MODE_W'($urandom_range(3)), pick_sample(), pick_sample());
    endtask

    // A restart first realigns the slot parity, then refs reference words follow
    // with a few measurements mixed in. A short run is broken off by the next
    // restart. A pause point, if not negative, drains the core mid-sequence.
    task automatic queue_calibration(input int hi_lvl, input int lo_lvl, input int spread,
                                     input int refs, input int pause_at);
        logic [SAMPLE_W-1:0] hi_code;
        logic [SAMPLE_W-1:0] lo_code;
        queue_conversion(MODE_RESTART, pick_sample(), pick_sample());
        for (int k = 0; k < refs; k++)
        begin
            if (k == pause_at)
                wait_all_results();
            if ($urandom_range(99) < 4)
                queue_conversion(MODE_MEAS, pick_sample(), pick_sample());
            hi_code = near_level(hi_lvl, spread);
            lo_code = near_level(lo_lvl, spread);
            // Even slots carry the high reference on the first converter.
            if (k % 2 == 0)
                queue_conversion(MODE_REF, hi_code, lo_code);
            else
                queue_conversion(MODE_REF, lo_code, hi_code);
        end
    endtask

    initial
    begin
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        // A write to an unassigned index must leave both ideal codes alone.
        write_ideal(CFG_SPARE, 12'hFFF);

        // Directed words at unity gain and zero offset.
        queue_conversion(MODE_MEAS, 12'd0, 12'd0);
        queue_conversion(MODE_MEAS, 12'hFFF, 12'hFFF);
        queue_conversion(MODE_MEAS, 12'hFFF, 12'd0);
        queue_conversion(MODE_MEAS, 12'd0, 12'hFFF);
        queue_conversion(MODE_MEAS, 12'd1, 12'd0);
        queue_conversion(MODE_REF, 12'hFFF, 12'd0);
        queue_conversion(MODE_REF, 12'd0, 12'hFFF);
        queue_conversion(MODE_UNUSED, 12'hFFF, 12'hFFF);
        queue_conversion(MODE_RESTART, 12'd0, 12'd0);
        queue_conversion(MODE_RESTART, 12'hFFF, 12'hFFF);
        queue_conversion(MODE_REF, 12'hAAA, 12'h555);
        queue_conversion(MODE_MEAS, 12'hAAA, 12'h555);
        queue_conversion(MODE_UNUSED, 12'd0, 12'd0);
        queue_conversion(MODE_RESTART, 12'h555, 12'hAAA);
        wait_all_results();

        // Reversed full-scale ideal codes and a high level just below the low one
        // make both numerator and divisor negative. The large gain saturates high
        // sums and the wrapped offset clamps low ones. No idling on either side.
        write_ideal(CFG_IDEAL_LOW, 12'hFFF);
        write_ideal(CFG_IDEAL_HIGH, 12'd0);
        steady = 1'b1;
        queue_calibration(2000, 2100, 3, CAL_REFS, CAL_REFS / 2);
        queue_measurements(8);
        wait_all_results();
        steady = 1'b0;
        queue_measurements(8);
        queue_noise(8);
        wait_all_results();

        // Equal reference levels leave a zero divisor: gain and offset must hold.
        write_ideal(CFG_IDEAL_LOW, SAMPLE_W'($urandom_range(SAMPLE_MAX)));
        write_ideal(CFG_IDEAL_HIGH, SAMPLE_W'($urandom_range(SAMPLE_MAX)));
        queue_calibration(2500, 2500, 0, CAL_REFS, -1);
        queue_measurements(8);
        queue_noise(8);
        wait_all_results();

        repeat (40) @(posedge clk);
        if (expected_readings.size() != 0)
            flag_mismatch("results never delivered", 0, expected_readings.size());

        $display("Covered %0d reference, %0d measurement, %0d restart, %0d unused-mode words.",
                 mode_count[MODE_REF], mode_count[MODE_MEAS], mode_count[MODE_RESTART],
                 mode_count[MODE_UNUSED]);
        $display("%0d calibrations closed, %0d hit equal averages; %0d saturated, %0d clamped",
                 cal_closed, cal_failed, saturated_count, clamped_count);
        $display("out of %0d results checked.", readings_checked);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("Timeout: results stopped arriving.");
        $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+sv
sv/adc_tpc_pkg.sv
sv/adc_tpc_div.sv
sv/adc_tpc_datapath.sv
sv/adc_tpc_ctrl.sv
sv/adc_two_point_calibration_core.sv
tb/testbench.sv
